// ----- src/assert_macros.svh -----
// Assertion macros used by the port checker of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/jdc_pkg.sv -----
// Shared constants for the joystick drive command block.
// Used by the core and by its port checker; depends on nothing.
package jdc_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_W      = 10;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned TGT_W      = 2;

  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned OUT_CMD_LSB = 0;
  localparam int unsigned OUT_SPD_LSB = 3;

  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd6;

  localparam logic [TGT_W-1:0] TGT_DRIVE = 2'd0;
  localparam logic [TGT_W-1:0] TGT_ARM   = 2'd1;
  localparam logic [TGT_W-1:0] TGT_GRIP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_RATE   = 3'd5;

  localparam logic [CFG_W-1:0]   CENTER_RST     = 10'd512;
  localparam logic [CFG_W-1:0]   DEAD_BAND_RST  = 10'd100;
  localparam logic [SPEED_W-1:0] SPEED_STEP_RST = 8'd20;
  localparam logic [SPEED_W-1:0] ARM_RATE_RST   = 8'd200;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;
  localparam int unsigned        Y_MARGIN  = 10;

endpackage

// ----- src/joystick_drive_command_core.sv -----
// Joystick drive command core: maps stick frames to drive, arm and gripper commands.
// Depends on jdc_pkg. A frame beat passes S_PREP, S_SCALE, the 8-step restoring divider
// and S_DECIDE before S_EMIT; the divider is skipped when the speed is zero or saturated.
// Further results of a frame follow one per cycle while the output is not stalled; a
// frame taken while disabled is dropped and gives no result.
// Reset (async, active low) restores the register defaults and a stopped, open state.
module joystick_drive_command_core #(
  parameter int unsigned SAMPLE_BITS = jdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // motor_x, motor_y, arm_x, arm_y, grip_closed, zero padding
  input  logic [((4*SAMPLE_BITS+8)/8)*8-1:0]     s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // command[2:0], speed[10:3], zero padding
  output logic [jdc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // target
  output logic [jdc_pkg::TGT_W-1:0]              m_axis_tuser_o,
  output logic                                   m_axis_tlast_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [jdc_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned CW = jdc_pkg::CFG_W;
  localparam int unsigned SW = jdc_pkg::SPEED_W;
  localparam int unsigned AW = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
  localparam int unsigned NW = AW + SW;
  localparam logic [AW+1:0] FULL_SCALE = (AW+2)'((1 << SAMPLE_BITS) - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_SCALE  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  // Returns the sign of sample minus center in the top bit and the magnitude below it.
  function automatic logic [AW:0] abs_dev(input logic [SAMPLE_BITS-1:0] s,
                                          input logic [CW-1:0] c);
    logic [AW:0] d;
    logic [AW:0] m;
    d = (AW+1)'(s) - (AW+1)'(c);
    m = d[AW] ? (AW+1)'(-d) : d;
    return {d[AW], m[AW-1:0]};
  endfunction

  function automatic logic [jdc_pkg::CMD_W-1:0] stick_dir(input logic [AW:0] xv,
                                                          input logic [AW:0] yv,
                                                          input logic [CW-1:0] dz);
    logic [AW-1:0]              xa;
    logic [AW-1:0]              ya;
    logic [AW-1:0]              dze;
    logic [AW:0]                xm;
    logic [jdc_pkg::CMD_W-1:0]  dir;
    xa  = xv[AW-1:0];
    ya  = yv[AW-1:0];
    dze = AW'(dz);
    xm  = {1'b0, xa} + (AW+1)'(jdc_pkg::Y_MARGIN);
    dir = jdc_pkg::CMD_STOP;
    if (xa > dze || ya > dze) begin
      if ({1'b0, ya} > xm) begin
        if (ya > dze) begin
          dir = yv[AW] ? jdc_pkg::CMD_BACK : jdc_pkg::CMD_FWD;
        end
      end else if (xa > dze) begin
        dir = xv[AW] ? jdc_pkg::CMD_RIGHT : jdc_pkg::CMD_LEFT;
      end
    end
    return dir;
  endfunction

  logic [2:0]                state_q, state_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [2:0]                pend_q, pend_d;
  logic                      out_valid_q, out_valid_d;

  logic                      enable_q;
  logic [CW-1:0]             center_x_q, center_y_q, dead_band_q;
  logic [SW-1:0]             speed_step_q, arm_rate_q;

  logic [jdc_pkg::CMD_W-1:0] ddir_now_q, ddir_now_d, ddir_sent_q, ddir_sent_d;
  logic [SW-1:0]             dspd_now_q, dspd_now_d, dspd_sent_q, dspd_sent_d;
  logic [jdc_pkg::CMD_W-1:0] adir_now_q, adir_now_d;
  logic                      grip_now_q, grip_now_d;

  logic [SAMPLE_BITS-1:0]    mx_q, my_q, ax_q, ay_q;
  logic                      grip_q;
  logic [jdc_pkg::CMD_W-1:0] ddir_q, ddir_d, adir_q, adir_d;
  logic [AW-1:0]             dev_q, dev_d, den_q, den_d;
  logic                      zero_q, zero_d, sat_q, sat_d;
  logic [NW-1:0]             rem_q, rem_d, dsh_q, dsh_d;
  logic [SW-1:0]             quo_q, quo_d;
  logic [jdc_pkg::CMD_W-1:0] out_cmd_q, out_cmd_d;
  logic [SW-1:0]             out_spd_q, out_spd_d;
  logic [jdc_pkg::TGT_W-1:0] out_tgt_q, out_tgt_d;
  logic                      out_last_q, out_last_d;

  logic                      load_in;
  logic [AW:0]               mxd, myd, axd, ayd;
  logic [CW-1:0]             cmax;
  logic [AW+1:0]             rng;
  logic [AW-1:0]             excess;
  logic [NW-1:0]             num;
  logic                      ge;
  logic                      dchg, dsend;
  logic [SW-1:0]             sdiff;
  logic [2:0]                pend_nx;
  logic                      out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign load_in         = s_axis_tvalid_i && s_axis_tready_o && enable_q;

  assign mxd  = abs_dev(mx_q, center_x_q);
  assign myd  = abs_dev(my_q, center_y_q);
  assign axd  = abs_dev(ax_q, center_x_q);
  assign ayd  = abs_dev(ay_q, center_y_q);
  assign cmax = (center_x_q > center_y_q) ? center_x_q : center_y_q;
  assign rng  = FULL_SCALE - (AW+2)'(cmax) - (AW+2)'(dead_band_q);

  assign excess = dev_q - AW'(dead_band_q);
  assign num    = {excess, {SW{1'b0}}} - NW'(excess);
  assign ge     = (rem_q >= dsh_q);

  assign dchg  = (ddir_q != ddir_now_q) || (quo_q != dspd_now_q);
  assign sdiff = (quo_q > dspd_sent_q) ? (quo_q - dspd_sent_q) : (dspd_sent_q - quo_q);
  assign dsend = dchg && ((ddir_q != ddir_sent_q) || (sdiff >= speed_step_q));

  assign pend_nx  = pend_q & (pend_q - 3'd1);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    ddir_now_d  = ddir_now_q;
    dspd_now_d  = dspd_now_q;
    ddir_sent_d = ddir_sent_q;
    dspd_sent_d = dspd_sent_q;
    adir_now_d  = adir_now_q;
    grip_now_d  = grip_now_q;
    ddir_d      = ddir_q;
    adir_d      = adir_q;
    dev_d       = dev_q;
    den_d       = den_q;
    zero_d      = zero_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    out_cmd_d   = out_cmd_q;
    out_spd_d   = out_spd_q;
    out_tgt_d   = out_tgt_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (load_in) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        ddir_d  = stick_dir(mxd, myd, dead_band_q);
        adir_d  = stick_dir(axd, ayd, dead_band_q);
        dev_d   = (mxd[AW-1:0] > myd[AW-1:0]) ? mxd[AW-1:0] : myd[AW-1:0];
        zero_d  = (mxd[AW-1:0] <= AW'(dead_band_q)) && (myd[AW-1:0] <= AW'(dead_band_q));
        sat_d   = rng[AW+1] || (rng == '0);
        den_d   = rng[AW-1:0];
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (zero_q) begin
          quo_d   = '0;
          state_d = S_DECIDE;
        end else if (sat_q || (num >= {den_q, {SW{1'b0}}})) begin
          quo_d   = jdc_pkg::SPEED_MAX;
          state_d = S_DECIDE;
        end else begin
          rem_d   = num;
          dsh_d   = {1'b0, den_q, {(SW-1){1'b0}}};
          quo_d   = '0;
          cnt_d   = 3'd7;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        quo_d = {quo_q[SW-2:0], ge};
        rem_d = ge ? (rem_q - dsh_q) : rem_q;
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd0) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (dchg) begin
          ddir_now_d = ddir_q;
          dspd_now_d = quo_q;
        end
        if (dsend) begin
          ddir_sent_d = ddir_q;
          dspd_sent_d = quo_q;
        end
        adir_now_d = adir_q;
        grip_now_d = grip_q;
        pend_d     = {grip_q != grip_now_q, adir_q != adir_now_q, dsend};
        state_d    = (dsend || (adir_q != adir_now_q) || (grip_q != grip_now_q))
                     ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (pend_nx == 3'd0);
          pend_d      = pend_nx;
          if (pend_q[0]) begin
            out_tgt_d = jdc_pkg::TGT_DRIVE;
            out_cmd_d = ddir_sent_q;
            out_spd_d = dspd_sent_q;
          end else if (pend_q[1]) begin
            out_tgt_d = jdc_pkg::TGT_ARM;
            out_cmd_d = adir_now_q;
            out_spd_d = (adir_now_q == jdc_pkg::CMD_STOP) ? '0 : arm_rate_q;
          end else begin
            out_tgt_d = jdc_pkg::TGT_GRIP;
            out_cmd_d = grip_now_q ? jdc_pkg::CMD_CLOSE : jdc_pkg::CMD_OPEN;
            out_spd_d = '0;
          end
          if (pend_nx == 3'd0) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
      enable_q     <= 1'b0;
      center_x_q   <= jdc_pkg::CENTER_RST;
      center_y_q   <= jdc_pkg::CENTER_RST;
      dead_band_q  <= jdc_pkg::DEAD_BAND_RST;
      speed_step_q <= jdc_pkg::SPEED_STEP_RST;
      arm_rate_q   <= jdc_pkg::ARM_RATE_RST;
      ddir_now_q   <= jdc_pkg::CMD_STOP;
      dspd_now_q   <= '0;
      ddir_sent_q  <= jdc_pkg::CMD_STOP;
      dspd_sent_q  <= '0;
      adir_now_q   <= jdc_pkg::CMD_STOP;
      grip_now_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      ddir_now_q  <= ddir_now_d;
      dspd_now_q  <= dspd_now_d;
      ddir_sent_q <= ddir_sent_d;
      dspd_sent_q <= dspd_sent_d;
      adir_now_q  <= adir_now_d;
      grip_now_q  <= grip_now_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          jdc_pkg::REG_ENABLE:     enable_q     <= cfg_data_i[0];
          jdc_pkg::REG_CENTER_X:   center_x_q   <= cfg_data_i[CW-1:0];
          jdc_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data_i[CW-1:0];
          jdc_pkg::REG_DEAD_BAND:  dead_band_q  <= cfg_data_i[CW-1:0];
          jdc_pkg::REG_SPEED_STEP: speed_step_q <= cfg_data_i[SW-1:0];
          jdc_pkg::REG_ARM_RATE:   arm_rate_q   <= cfg_data_i[SW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      mx_q   <= s_axis_tdata_i[0 +: SAMPLE_BITS];
      my_q   <= s_axis_tdata_i[SAMPLE_BITS +: SAMPLE_BITS];
      ax_q   <= s_axis_tdata_i[2*SAMPLE_BITS +: SAMPLE_BITS];
      ay_q   <= s_axis_tdata_i[3*SAMPLE_BITS +: SAMPLE_BITS];
      grip_q <= s_axis_tdata_i[4*SAMPLE_BITS];
    end
    ddir_q     <= ddir_d;
    adir_q     <= adir_d;
    dev_q      <= dev_d;
    den_q      <= den_d;
    zero_q     <= zero_d;
    sat_q      <= sat_d;
    rem_q      <= rem_d;
    dsh_q      <= dsh_d;
    quo_q      <= quo_d;
    out_cmd_q  <= out_cmd_d;
    out_spd_q  <= out_spd_d;
    out_tgt_q  <= out_tgt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(jdc_pkg::OUT_TDATA_W - jdc_pkg::CMD_W - SW){1'b0}},
                            out_spd_q, out_cmd_q};
  assign m_axis_tuser_o  = out_tgt_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ----- src/jdc_checker.sv -----
// Port checker for the joystick drive command core, bound to its top level.
// Depends on jdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_tvalid_i,
  input logic                              m_tready_i,
  input logic [jdc_pkg::OUT_TDATA_W-1:0]   m_tdata_i,
  input logic [jdc_pkg::TGT_W-1:0]         m_tuser_i,
  input logic                              m_tlast_i
);

  logic [jdc_pkg::CMD_W-1:0]   cmd;
  logic [jdc_pkg::SPEED_W-1:0] spd;

  assign cmd = m_tdata_i[jdc_pkg::OUT_CMD_LSB +: jdc_pkg::CMD_W];
  assign spd = m_tdata_i[jdc_pkg::OUT_SPD_LSB +: jdc_pkg::SPEED_W];

  `ASSERT_NXT(a_out_hold, m_tvalid_i && !m_tready_i,
              m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) && $stable(m_tlast_i),
              "Result beat changed while stalled.")
  `ASSERT_NXT(a_frame_order, m_tvalid_i && m_tready_i && !m_tlast_i,
              m_tvalid_i && (m_tuser_i > $past(m_tuser_i)),
              "Results of one frame are not back to back in target order.")
  `ASSERT_IMP(a_grip_cmd, m_tvalid_i && (m_tuser_i == jdc_pkg::TGT_GRIP),
              (spd == '0) && ((cmd == jdc_pkg::CMD_OPEN) || (cmd == jdc_pkg::CMD_CLOSE)),
              "Gripper result carries a bad command or a speed.")
  `ASSERT_IMP(a_move_cmd, m_tvalid_i && (m_tuser_i != jdc_pkg::TGT_GRIP),
              (cmd <= jdc_pkg::CMD_RIGHT),
              "Drive or arm result carries a gripper command.")
  `ASSERT_IMP(a_arm_stop, m_tvalid_i && (m_tuser_i == jdc_pkg::TGT_ARM) &&
              (cmd == jdc_pkg::CMD_STOP), (spd == '0),
              "Arm stop sent with a nonzero speed.")

endmodule

bind joystick_drive_command_core jdc_checker u_jdc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);
